// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way merge heap block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int DEF_MAX_RUNS  = 16;
    localparam int DEF_KEY_WIDTH = 64;
    localparam int VALUE_W       = 64;
    localparam int SRC_W         = 4;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] RUN_COUNT_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PU_CHK,
        S_PU_CMP,
        S_POP,
        S_POP_TOP,
        S_POP_LAST,
        S_SD_CHK,
        S_SD_L,
        S_SD_R,
        S_SD_DEC,
        S_EMIT
    } kwm_state_t;

endpackage

// ===== rtl/kwm_cmp.sv =====
// ----------------------------------------------------------------------------
// kwm_cmp
// Shared order compare: true when entry a leaves the heap before entry b.
// ----------------------------------------------------------------------------
module kwm_cmp #(
    parameter int KEY_WIDTH = 64,
    parameter int RUN_W     = 4
) (
    input  logic [kwm_pkg::VALUE_W-1:0] a_value,
    input  logic [RUN_W-1:0]            a_run,
    input  logic [kwm_pkg::VALUE_W-1:0] b_value,
    input  logic [RUN_W-1:0]            b_run,
    output logic                        precedes
);
    import kwm_pkg::*;

    logic [VALUE_W-1:0]   a_flip;
    logic [VALUE_W-1:0]   b_flip;
    logic [KEY_WIDTH-1:0] a_key;
    logic [KEY_WIDTH-1:0] b_key;

    // Flip sign: invert negatives, set sign bit of non-negatives
    assign a_flip = a_value[VALUE_W-1] ? ~a_value : (a_value | {1'b1, {(VALUE_W-1){1'b0}}});
    assign b_flip = b_value[VALUE_W-1] ? ~b_value : (b_value | {1'b1, {(VALUE_W-1){1'b0}}});
    assign a_key  = a_flip[VALUE_W-1 -: KEY_WIDTH];
    assign b_key  = b_flip[VALUE_W-1 -: KEY_WIDTH];

    // Break ties on the lower run index
    assign precedes = (a_key != b_key) ? (a_key < b_key) : (a_run < b_run);

endmodule

// ===== rtl/kwm_heap_mem.sv =====
// ----------------------------------------------------------------------------
// kwm_heap_mem
// Heap entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kwm_heap_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 68
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read entry into a registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/kway_merge_heap.sv =====
// ----------------------------------------------------------------------------
// kway_merge_heap
// K-way merge of sorted runs of IEEE doubles through a binary min-heap.
// ----------------------------------------------------------------------------
// Load one head item per run (run 0 first); once run_count heads (clamped
// to MAX_RUNS) are in, the block emits the smallest head and its run, and
// each later item refills (or closes, present=0) the run just emitted and
// yields the next smallest head. A refill climbs the heap, reading each
// parent and then comparing and writing, and writes the entry at the root if
// it gets there. A pop reads the root and the last entry, then descends level
// by level with up to two reads and two compares per level (through the
// single heap memory port and the single compare unit), parks the entry, and
// emits the head, waiting for the output register if it is still full.
// in_ready is high only while no item is at work. Results sit in an output
// register until taken. last marks the emission that empties the heap; an
// item that finds the heap empty ends the merge silently and the block
// returns to loading.
// ----------------------------------------------------------------------------
module kway_merge_heap #(
    parameter int MAX_RUNS  = kwm_pkg::DEF_MAX_RUNS,
    parameter int KEY_WIDTH = kwm_pkg::DEF_KEY_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]   run_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [kwm_pkg::VALUE_W-1:0] next_value,
    input  logic                        present,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kwm_pkg::VALUE_W-1:0] sorted_value,
    output logic [kwm_pkg::SRC_W-1:0]   source_run,
    output logic                        last
);
    import kwm_pkg::*;

    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int L_W   = IDX_W + 2;
    localparam int ENT_W = VALUE_W + IDX_W;

    kwm_state_t state_reg, state_next;

    logic [CFG_W-1:0]   run_count_reg;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]   lc_reg, lc_next;
    logic [IDX_W-1:0]   pend_reg, pend_next;
    logic               phase_reg, phase_next;
    logic               go_pop_reg, go_pop_next;
    logic [IDX_W-1:0]   hole_reg, hole_next;
    logic [VALUE_W-1:0] cur_val_reg, cur_val_next;
    logic [IDX_W-1:0]   cur_run_reg, cur_run_next;
    logic [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]   best_run_reg, best_run_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [VALUE_W-1:0] top_val_reg, top_val_next;
    logic [IDX_W-1:0]   top_run_reg, top_run_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_val_reg, out_val_next;
    logic [SRC_W-1:0]   out_src_reg, out_src_next;
    logic               out_last_reg, out_last_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENT_W-1:0]   rd_data;
    logic [VALUE_W-1:0] rd_val;
    logic [IDX_W-1:0]   rd_run;

    logic [VALUE_W-1:0] cmp_a_val;
    logic [IDX_W-1:0]   cmp_a_run;
    logic [VALUE_W-1:0] cmp_b_val;
    logic [IDX_W-1:0]   cmp_b_run;
    logic               cmp_prec;

    logic [L_W-1:0]     l_wide;
    logic [L_W-1:0]     r_wide;
    logic [L_W-1:0]     size_wide;
    logic [IDX_W-1:0]   parent_idx;
    logic [CNT_W-1:0]   size_dec;
    logic [CNT_W-1:0]   lc_inc;
    logic               load_done;

    assign rd_val = rd_data[ENT_W-1 -: VALUE_W];
    assign rd_run = rd_data[IDX_W-1:0];

    // Heap address arithmetic
    assign l_wide     = {1'b0, hole_reg, 1'b1};
    assign r_wide     = l_wide + 1'b1;
    assign size_wide  = L_W'(size_reg);
    assign parent_idx = IDX_W'((hole_reg - 1'b1) >> 1);
    assign size_dec   = size_reg - 1'b1;
    assign lc_inc     = lc_reg + 1'b1;

    // Loading ends when the count reaches the clamped run count
    assign load_done = (32'(lc_inc) >= 32'(MAX_RUNS)) || (32'(lc_inc) >= 32'(run_count_reg))
                       || (run_count_reg == '0);

    kwm_heap_mem #(
        .DEPTH (MAX_RUNS),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Route compare operands: climbing compares the hole entry with its
    // parent, descending compares a child with the best so far
    always_comb
    begin
        if (state_reg == S_PU_CMP)
        begin
            cmp_a_val = cur_val_reg;
            cmp_a_run = cur_run_reg;
            cmp_b_val = rd_val;
            cmp_b_run = rd_run;
        end
        else
        begin
            cmp_a_val = rd_val;
            cmp_a_run = rd_run;
            cmp_b_val = best_val_reg;
            cmp_b_run = best_run_reg;
        end
    end

    kwm_cmp #(
        .KEY_WIDTH (KEY_WIDTH),
        .RUN_W     (IDX_W)
    ) u_cmp (
        .a_value  (cmp_a_val),
        .a_run    (cmp_a_run),
        .b_value  (cmp_b_val),
        .b_run    (cmp_b_run),
        .precedes (cmp_prec)
    );

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign sorted_value = out_val_reg;
    assign source_run   = out_src_reg;
    assign last         = out_last_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        lc_next        = lc_reg;
        pend_next      = pend_reg;
        phase_next     = phase_reg;
        go_pop_next    = go_pop_reg;
        hole_next      = hole_reg;
        cur_val_next   = cur_val_reg;
        cur_run_next   = cur_run_reg;
        best_val_next  = best_val_reg;
        best_run_next  = best_run_reg;
        best_idx_next  = best_idx_reg;
        top_val_next   = top_val_reg;
        top_run_next   = top_run_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_src_next   = out_src_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = {cur_val_reg, cur_run_reg};
        rd_en          = 1'b0;
        rd_addr        = '0;

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_val_next = next_value;
                    if (!phase_reg)
                    begin
                        cur_run_next = lc_reg[IDX_W-1:0];
                        lc_next      = lc_inc;
                        go_pop_next  = load_done;
                        if (load_done)
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_run_next = pend_reg;
                        go_pop_next  = 1'b1;
                    end
                    if (present && (32'(size_reg) < 32'(MAX_RUNS)))
                    begin
                        hole_next  = size_reg[IDX_W-1:0];
                        size_next  = size_reg + 1'b1;
                        state_next = S_PU_CHK;
                    end
                    else if (!phase_reg && !load_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            // Climb: fetch the parent or settle at the root
            S_PU_CHK:
            begin
                if (hole_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = go_pop_reg ? S_POP : S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = S_PU_CMP;
                end
            end

            S_PU_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_prec)
                begin
                    wr_data    = rd_data;
                    hole_next  = parent_idx;
                    state_next = S_PU_CHK;
                end
                else
                begin
                    state_next = go_pop_reg ? S_POP : S_IDLE;
                end
            end

            // Start a pop, or end the merge on an empty heap
            S_POP:
            begin
                if (size_reg == '0)
                begin
                    phase_next = 1'b0;
                    lc_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_POP_TOP;
                end
            end

            S_POP_TOP:
            begin
                top_val_next = rd_val;
                top_run_next = rd_run;
                rd_en        = 1'b1;
                rd_addr      = size_dec[IDX_W-1:0];
                state_next   = S_POP_LAST;
            end

            S_POP_LAST:
            begin
                cur_val_next = rd_val;
                cur_run_next = rd_run;
                size_next    = size_dec;
                hole_next    = '0;
                state_next   = S_SD_CHK;
            end

            // Descend: fetch the left child or settle here
            S_SD_CHK:
            begin
                if (l_wide >= size_wide)
                begin
                    wr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = l_wide[IDX_W-1:0];
                    best_val_next = cur_val_reg;
                    best_run_next = cur_run_reg;
                    best_idx_next = hole_reg;
                    state_next    = S_SD_L;
                end
            end

            S_SD_L:
            begin
                if (cmp_prec)
                begin
                    best_val_next = rd_val;
                    best_run_next = rd_run;
                    best_idx_next = l_wide[IDX_W-1:0];
                end
                if (r_wide < size_wide)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = r_wide[IDX_W-1:0];
                    state_next = S_SD_R;
                end
                else
                begin
                    state_next = S_SD_DEC;
                end
            end

            S_SD_R:
            begin
                if (cmp_prec)
                begin
                    best_val_next = rd_val;
                    best_run_next = rd_run;
                    best_idx_next = r_wide[IDX_W-1:0];
                end
                state_next = S_SD_DEC;
            end

            // Move the smaller child up, or park the entry
            S_SD_DEC:
            begin
                wr_en = 1'b1;
                if (best_idx_reg == hole_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    wr_data    = {best_val_reg, best_run_reg};
                    hole_next  = best_idx_reg;
                    state_next = S_SD_CHK;
                end
            end

            // Hand the popped head to the output register
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = top_val_reg;
                    out_src_next   = SRC_W'(top_run_reg);
                    out_last_next  = (size_reg == '0);
                    pend_next      = top_run_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_count_reg <= RUN_COUNT_RESET;
            size_reg      <= '0;
            lc_reg        <= '0;
            pend_reg      <= '0;
            phase_reg     <= 1'b0;
            go_pop_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            lc_reg        <= lc_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            go_pop_reg    <= go_pop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                run_count_reg <= run_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        cur_val_reg  <= cur_val_next;
        cur_run_reg  <= cur_run_next;
        best_val_reg <= best_val_next;
        best_run_reg <= best_run_next;
        best_idx_reg <= best_idx_next;
        top_val_reg  <= top_val_next;
        top_run_reg  <= top_run_next;
        out_val_reg  <= out_val_next;
        out_src_reg  <= out_src_next;
        out_last_reg <= out_last_next;
    end

endmodule
